@@ rtl/pzc_pkg.sv @@
// Shared types, codes and digit/bar helper functions for the POSTNET zip codec.
package pzc_pkg;

    localparam int ZIP_W  = 17;
    localparam int BARS_W = 27;
    localparam int STAT_W = 2;

    typedef logic [ZIP_W-1:0]  t_zip;
    typedef logic [BARS_W-1:0] t_bars;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [3:0]        t_digit;
    typedef logic [4:0]        t_group;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_ZIP_BIG = 2'd1;
    localparam t_status ST_FRAME   = 2'd2;
    localparam t_status ST_GROUP   = 2'd3;

    localparam t_zip ZIP_LIMIT = 17'd100000;

    // reciprocal multipliers: floor(x / d) == (x * K) >> S, exact for x < 100000
    localparam logic [17:0] K_DIV10000 = 18'd214749; // S = 31
    localparam logic [17:0] K_DIV1000  = 18'd134218; // S = 27
    localparam logic [17:0] K_DIV100   = 18'd167773; // S = 24
    localparam logic [17:0] K_DIV10    = 18'd104858; // S = 20

    // one conversion result
    typedef struct packed {
        t_zip    zip;
        t_bars   bars;
        t_status status;
    } t_result;

    // two-of-five pattern of a digit, first bar in bit 4
    function automatic t_group digit_pattern(input t_digit d);
        t_group p;
        case (d)
            4'd0:    p = 5'b11000;
            4'd1:    p = 5'b00011;
            4'd2:    p = 5'b00101;
            4'd3:    p = 5'b00110;
            4'd4:    p = 5'b01001;
            4'd5:    p = 5'b01010;
            4'd6:    p = 5'b01100;
            4'd7:    p = 5'b10001;
            4'd8:    p = 5'b10010;
            4'd9:    p = 5'b10100;
            default: p = 5'b00000;
        endcase
        return p;
    endfunction

    // true when the group holds exactly two full bars
    function automatic logic two_of_five(input t_group g);
        logic [2:0] n;
        n = 3'(g[4]) + 3'(g[3]) + 3'(g[2]) + 3'(g[1]) + 3'(g[0]);
        return (n == 3'd2);
    endfunction

    // weights 7,4,2,1,0; a weighted sum of eleven stands for zero
    function automatic t_digit group_digit(input t_group g);
        t_digit s;
        s = (g[4] ? 4'd7 : 4'd0) + (g[3] ? 4'd4 : 4'd0)
          + (g[2] ? 4'd2 : 4'd0) + (g[1] ? 4'd1 : 4'd0);
        if (s == 4'd11) begin
            s = 4'd0;
        end
        return s;
    endfunction

endpackage

@@ rtl/pzc_encoder.sv @@
// Zip value to 27-bar code: range check, decimal split and pattern lookup.
module pzc_encoder (
    input  pzc_pkg::t_zip    i_zip,
    output pzc_pkg::t_result o_res
);
    import pzc_pkg::*;

    logic [34:0] p4, p3, p2, p1;
    logic [6:0]  q3, t3;
    logic [9:0]  q2, t2;
    logic [13:0] q1, t1;
    t_zip        t0;
    t_digit      d4, d3, d2, d1, d0;

    // quotients by 10000, 1000, 100 and 10 in parallel
    assign p4 = 35'(i_zip) * 35'(K_DIV10000);
    assign p3 = 35'(i_zip) * 35'(K_DIV1000);
    assign p2 = 35'(i_zip) * 35'(K_DIV100);
    assign p1 = 35'(i_zip) * 35'(K_DIV10);

    assign d4 = p4[34:31];
    assign q3 = p3[33:27];
    assign q2 = p2[33:24];
    assign q1 = p1[33:20];

    // each digit is a quotient less ten times the next coarser one
    assign t3 = q3 - 7'(d4) * 7'd10;
    assign t2 = q2 - 10'(q3) * 10'd10;
    assign t1 = q1 - 14'(q2) * 14'd10;
    assign t0 = i_zip - 17'(q1) * 17'd10;

    assign d3 = t3[3:0];
    assign d2 = t2[3:0];
    assign d1 = t1[3:0];
    assign d0 = t0[3:0];

    always_comb begin
        if (i_zip >= ZIP_LIMIT) begin
            o_res.zip    = '0;
            o_res.bars   = '0;
            o_res.status = ST_ZIP_BIG;
        end else begin
            o_res.zip    = i_zip;
            o_res.bars   = {1'b1, digit_pattern(d4), digit_pattern(d3), digit_pattern(d2),
                            digit_pattern(d1), digit_pattern(d0), 1'b1};
            o_res.status = ST_OK;
        end
    end

endmodule

@@ rtl/pzc_decoder.sv @@
// 27-bar code to zip value: frame and group checks, digit weighting, decimal sum.
module pzc_decoder (
    input  pzc_pkg::t_bars   i_bars,
    output pzc_pkg::t_result o_res
);
    import pzc_pkg::*;

    t_group g4, g3, g2, g1, g0;
    logic   groups_ok;
    t_zip   value;

    assign g4 = i_bars[25:21];
    assign g3 = i_bars[20:16];
    assign g2 = i_bars[15:11];
    assign g1 = i_bars[10:6];
    assign g0 = i_bars[5:1];

    assign groups_ok = two_of_five(g4) & two_of_five(g3) & two_of_five(g2)
                     & two_of_five(g1) & two_of_five(g0);

    assign value = 17'(group_digit(g4)) * 17'd10000 + 17'(group_digit(g3)) * 17'd1000
                 + 17'(group_digit(g2)) * 17'd100 + 17'(group_digit(g1)) * 17'd10
                 + 17'(group_digit(g0));

    always_comb begin
        o_res.zip  = '0;
        o_res.bars = '0;
        if (!i_bars[26] || !i_bars[0]) begin
            o_res.status = ST_FRAME;     // frame check wins over group check
        end else if (!groups_ok) begin
            o_res.status = ST_GROUP;
        end else begin
            o_res.zip    = value;
            o_res.bars   = i_bars;
            o_res.status = ST_OK;
        end
    end

endmodule

@@ rtl/postnet_zip_codec_core.sv @@
// Top level of the POSTNET five-digit zip codec.
// Each transfer in asks to encode a zip value (operation 0) into the 27-bar
// two-of-five code, or to decode a 27-bar code (operation 1) back into the value;
// every transfer in yields exactly one transfer out, in order. Bit 26 of a bar word
// is the first bar and 1 is a full bar. Status 0 is success; 1 means the zip value
// was 100000 or more, 2 a missing frame bar, 3 a group without exactly two full bars
// (the frame check is made first). On any error zip_out and bars_out are zero. On a
// good encode the zip value is echoed; on a good decode the bars are echoed.
// A transfer in passes through one input register, one single pass of conversion
// logic and one result register before its result is valid. One item is taken every
// cycle; throughput is limited only by downstream stall. The block holds no state
// beyond the pipeline, so reset only empties the two stages.
module postnet_zip_codec_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  pzc_pkg::t_zip         i_zip_in,
    input  pzc_pkg::t_bars        i_bars_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pzc_pkg::t_zip         o_zip_out,
    output pzc_pkg::t_bars        o_bars_out,
    output pzc_pkg::t_status      o_status
);
    import pzc_pkg::*;

    // input register
    logic    r_s1_valid;
    logic    r_s1_op;
    t_zip    r_s1_zip;
    t_bars   r_s1_bars;

    // result register
    logic    r_out_valid;
    t_result r_out;

    t_result enc_res, dec_res;
    t_result n_out;
    logic    adv_out;   // result register may load
    logic    adv_s1;    // input register may load

    // Result stage moves when empty or when its transfer completes; the input
    // stage moves when it is empty or can hand over to the result stage.
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_s1     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_s1;

    pzc_encoder u_enc (
        .i_zip (r_s1_zip),
        .o_res (enc_res)
    );

    pzc_decoder u_dec (
        .i_bars (r_s1_bars),
        .o_res  (dec_res)
    );

    assign n_out = (r_s1_op == OP_DECODE) ? dec_res : enc_res;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_in_valid) begin
            r_s1_op   <= i_operation;
            r_s1_zip  <= i_zip_in;
            r_s1_bars <= i_bars_in;
        end
        if (adv_out && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_zip_out   = r_out.zip;
    assign o_bars_out  = r_out.bars;
    assign o_status    = r_out.status;

endmodule

@@ tb/sv/postnet_zip_codec_core_test.sv @@
// Self-checking testbench for the POSTNET five-digit zip codec core.
`timescale 1ns / 1ps

module postnet_zip_codec_core_test;
    import pzc_pkg::*;

    // Longest quiet stretch seen in a good run is the deliberate receiver hold
    // plus the pipeline delay; the watchdog allows several times that.
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    // Spare cycles after the last result, to catch strays.
    localparam int DRAIN_CYCLES   = 8;

    // Two-of-five bar pattern per digit, digit d in bits [5*d +: 5], first bar
    // of the group in the top bit of each slice.
    localparam logic [49:0] CODE_BOOK = {
        5'b10100, 5'b10010, 5'b10001, 5'b01100, 5'b01010,
        5'b01001, 5'b00110, 5'b00101, 5'b00011, 5'b11000
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    logic    i_operation;
    t_zip    i_zip_in;
    t_bars   i_bars_in;
    logic    o_out_valid;
    logic    i_out_stall;
    t_zip    o_zip_out;
    t_bars   o_bars_out;
    t_status o_status;

    // Results owed by the block, oldest first.
    t_result conversions_due[$];
    int      mismatch_count;
    int      quiet_cycles;
    // Idling switches for each side, and a one-shot request for a long hold.
    bit      tx_idle_on;
    bit      rx_idle_on;
    bit      long_hold_req;

    postnet_zip_codec_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_zip_in    (i_zip_in),
        .i_bars_in   (i_bars_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_zip_out   (o_zip_out),
        .o_bars_out  (o_bars_out),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Expected outcome of one conversion. Errors leave both data fields zero;
    // on decode the frame bars are checked before the groups.
    function automatic t_result convert_zip_bars(input logic op, input t_zip zip,
                                                 input t_bars bars);
        t_result     r;
        int unsigned value;
        int unsigned place;
        int unsigned sum;
        int unsigned digit;
        t_group      grp;
        r = '0;
        if (op == OP_ENCODE) begin
            if (zip >= ZIP_LIMIT) begin
                r.status = ST_ZIP_BIG;
            end else begin
                r.status   = ST_OK;
                r.zip      = zip;
                r.bars[26] = 1'b1;
                r.bars[0]  = 1'b1;
                place      = 10000;
                for (int i = 0; i < 5; i++) begin
                    digit = (int'(zip) / place) % 10;
                    r.bars[21-5*i +: 5] = CODE_BOOK[digit*5 +: 5];
                    place = place / 10;
                end
            end
        end else if (!bars[26] || !bars[0]) begin
            r.status = ST_FRAME;
        end else begin
            r.status = ST_OK;
            value    = 0;
            for (int i = 0; i < 5; i++) begin
                grp = bars[21-5*i +: 5];
                if ($countones(grp) != 2) begin
                    r.status = ST_GROUP;
                end
                // weights 7,4,2,1,0; eleven stands for zero
                sum = (grp[4] ? 7 : 0) + (grp[3] ? 4 : 0) + (grp[2] ? 2 : 0)
                    + (grp[1] ? 1 : 0);
                if (sum == 11) begin
                    sum = 0;
                end
                value = value * 10 + sum;
            end
            if (r.status == ST_OK) begin
                r.zip  = t_zip'(value);
                r.bars = bars;
            end
        end
        return r;
    endfunction

    // Offer one item after a drawn gap and hold it until the transfer. Called
    // and returning in the active region just after a rising edge.
    task automatic offer_conversion(input logic op, input t_zip zip, input t_bars bars);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_zip_in    <= zip;
        i_bars_in   <= bars;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && !o_in_stall));
        conversions_due.push_back(convert_zip_bars(op, zip, bars));
    endtask

    // Encode at the range ends, across all ten digits and past the limit.
    task automatic test_encode_limits();
        offer_conversion(OP_ENCODE, 17'd0,      t_bars'($urandom));
        offer_conversion(OP_ENCODE, 17'd99999,  t_bars'($urandom));
        offer_conversion(OP_ENCODE, 17'd13579,  t_bars'($urandom));
        offer_conversion(OP_ENCODE, 17'd2468,   t_bars'($urandom));
        offer_conversion(OP_ENCODE, 17'd100000, t_bars'($urandom));
        offer_conversion(OP_ENCODE, 17'd131071, t_bars'($urandom));
    endtask

    // Good codes for every digit, then each way a bar word can be rejected.
    task automatic test_decode_checks();
        t_result code;
        code = convert_zip_bars(OP_ENCODE, 17'd0, '0);
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars);
        code = convert_zip_bars(OP_ENCODE, 17'd99999, '0);
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars);
        code = convert_zip_bars(OP_ENCODE, 17'd13579, '0);
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars);
        code = convert_zip_bars(OP_ENCODE, 17'd2468, '0);
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars);

        // no bars at all, every bar full
        offer_conversion(OP_DECODE, t_zip'($urandom), '0);
        offer_conversion(OP_DECODE, t_zip'($urandom), '1);
        code = convert_zip_bars(OP_ENCODE, 17'd12345, '0);
        // first or last frame bar missing
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars & ~(27'h1 << 26));
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars & ~27'h1);
        // frame and a group both broken: frame wins
        offer_conversion(OP_DECODE, t_zip'($urandom),
                         (code.bars & ~27'h1) ^ (27'h1 << 5));
        // groups holding none, one, three and five full bars
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars & ~(27'h1F << 16));
        offer_conversion(OP_DECODE, t_zip'($urandom),
                         (code.bars & ~(27'h1F << 21)) | (27'h01 << 21));
        offer_conversion(OP_DECODE, t_zip'($urandom),
                         (code.bars & ~(27'h1F << 11)) | (27'h15 << 11));
        offer_conversion(OP_DECODE, t_zip'($urandom), code.bars | (27'h1F << 1));
    endtask

    // Mostly well-formed items with random content, some damaged codes and noise.
    task automatic offer_random_item();
        int      pick;
        t_result code;
        pick = $urandom_range(0, 99);
        code = convert_zip_bars(OP_ENCODE, t_zip'($urandom_range(0, 99999)), '0);
        if (pick < 40) begin
            offer_conversion(OP_DECODE, t_zip'($urandom), code.bars);
        end else if (pick < 55) begin
            offer_conversion(OP_DECODE, t_zip'($urandom),
                             code.bars ^ (27'h1 << $urandom_range(0, 26)));
        end else if (pick < 65) begin
            offer_conversion(OP_DECODE, t_zip'($urandom), t_bars'($urandom));
        end else if (pick < 90) begin
            offer_conversion(OP_ENCODE, t_zip'($urandom_range(0, 99999)),
                             t_bars'($urandom));
        end else if (pick < 95) begin
            offer_conversion(OP_ENCODE, t_zip'($urandom), t_bars'($urandom));
        end else begin
            offer_conversion(OP_ENCODE, t_zip'($urandom_range(100000, 131071)),
                             t_bars'($urandom));
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back to back, so the pipeline fills and the input stalls.
    task automatic test_back_pressure();
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) offer_random_item();
        tx_idle_on    = 1'b1;
    endtask

    task automatic test_random_traffic(input int count, input bit tx_idle,
                                       input bit rx_idle);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        repeat (count) offer_random_item();
    endtask

    // Result side: draw a stall length per result, honour the long-hold
    // request, then wait for the transfer.
    initial begin
        int hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!(o_out_valid && !i_out_stall));
        end
    end

    // Result checker: every transfer out against the oldest owed result.
    initial begin
        t_result due;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (conversions_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: zip=%0d bars=%h status=%0d",
                                 o_zip_out, o_bars_out, o_status);
                    end
                end else begin
                    due = conversions_due.pop_front();
                    if (o_zip_out !== due.zip || o_bars_out !== due.bars
                            || o_status !== due.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("exp zip=%0d bars=%h st=%0d, got zip=%0d bars=%h st=%0d",
                                     due.zip, due.bars, due.status,
                                     o_zip_out, o_bars_out, o_status);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: counts consecutive cycles without a transfer on either side.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("postnet_zip_codec_core: mismatch");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        long_hold_req  = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_ENCODE;
        i_zip_in    <= '0;
        i_bars_in   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_limits();
        test_decode_checks();
        test_back_pressure();
        // idling on both sides, none, then each side alone
        test_random_traffic(250, 1'b1, 1'b1);
        test_random_traffic(250, 1'b0, 1'b0);
        test_random_traffic(250, 1'b1, 1'b0);
        test_random_traffic(250, 1'b0, 1'b1);
        i_in_valid <= 1'b0;

        // drain: all owed results in, then a short tail for strays
        while (conversions_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && conversions_due.size() == 0) begin
            $display("postnet_zip_codec_core: match");
        end else begin
            $display("postnet_zip_codec_core: mismatch");
        end
        $finish;
    end

endmodule
